// ===== design/tensor_lagrange_shape_eval_defines.svh =====
// Assertion macros shared by the design files.
`ifndef TENSOR_LAGRANGE_SHAPE_EVAL_DEFINES_SVH
`define TENSOR_LAGRANGE_SHAPE_EVAL_DEFINES_SVH

`ifndef SYNTHESIS
`define TLSE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TLSE_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define TLSE_ASSERT(label, prop, msg)
`define TLSE_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ===== design/tlse_pkg.sv =====
package tlse_pkg;

  localparam int DATA_W     = 64;
  localparam int WEIGHT_W   = 48;
  localparam int COORD_W    = 32;
  localparam int NUM_COORDS = 4;
  localparam int CSW        = $clog2(NUM_COORDS);
  localparam int REG_IDX_W  = 3;
  localparam int NODE_IDX_W = 6;

  localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIMENSION  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COORD0     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COORD1     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COORD2     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COORD3     = 3'd5;

  localparam logic [1:0] DIM_LINE  = 2'd1;
  localparam logic [1:0] DIM_QUAD  = 2'd2;
  localparam logic [1:0] DIM_BRICK = 2'd3;

  localparam logic [2:0] NODE_COUNT_RST = 3'd4;
  localparam logic [1:0] DIM_RST        = DIM_LINE;
  localparam logic signed [COORD_W-1:0] COORD_RST [NUM_COORDS] =
    '{-32'sd1073741824, -32'sd477218588, 32'sd477218588, 32'sd1073741824};

  localparam logic [WEIGHT_W-1:0] WEIGHT_LIMIT = 48'h7FFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0]   DATA_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic {OP_MUL, OP_RECIP} alu_op_e;
  typedef enum logic [1:0] {SH_FRAC, SH_WEIGHT, SH_PDERIV, SH_DERIV} sh_sel_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
    sh_sel_e sh;
  } alu_req_t;

  typedef struct packed {
    logic done;
  } alu_rsp_t;

  typedef enum logic [2:0] {A_IDLE, A_MUL, A_FIN, A_DIV, A_DFIN} alu_st_e;

  typedef enum logic [4:0] {
    S_IDLE, S_W_J, S_W_I, S_W_M, S_W_R,
    S_B_START, S_B_P, S_B_PM, S_B_V, S_B_VM, S_B_K, S_B_T, S_B_TM, S_B_DM,
    S_O_ISSUE, S_O_WAIT, S_O_EMIT
  } seq_state_e;

endpackage

// ===== design/tensor_lagrange_shape_eval.sv =====
// Every multiply runs in the shared ALU as four 32x32 partial products.
// A reciprocal for a barycentric weight runs in the same unit.
// One point first builds the basis values and derivatives per node and axis, then takes M
// multiplies per result with M = 1, 3 or 7 for a line, quad or brick.
// Weights are rebuilt before the first point after reset or after any register write.
// Reset is asynchronous and active low; configuration registers return to their defaults in tlse_pkg.
`include "tensor_lagrange_shape_eval_defines.svh"

module tensor_lagrange_shape_eval #(
  parameter int MAX_NODES = 4,
  parameter int FRAC_BITS = 30
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tlse_pkg::REG_IDX_W-1:0]     cfg_idx_i,
  input  logic [31:0]                        cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [31:0]                 coord_x_i,
  input  logic signed [31:0]                 coord_y_i,
  input  logic signed [31:0]                 coord_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [tlse_pkg::NODE_IDX_W-1:0]    node_index_o,
  output logic signed [31:0]                 shape_value_o,
  output logic signed [31:0]                 deriv_x_o,
  output logic signed [31:0]                 deriv_y_o,
  output logic signed [31:0]                 deriv_z_o,
  output logic                               last_node_o
);
  import tlse_pkg::*;

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [64:0] MAX65 = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic [2:0] LAST_STEP_LINE  = 3'd0;
  localparam logic [2:0] LAST_STEP_QUAD  = 3'd2;
  localparam logic [2:0] LAST_STEP_BRICK = 3'd6;

  seq_state_e state_q, state_d;

  logic [2:0]  node_count_q;
  logic [1:0]  dimension_q;
  logic signed [31:0] node_coord_q [NUM_COORDS];
  logic        wvalid_q;
  logic        out_valid_q;

  logic [CW-1:0] n_q, i_q, j_q, k_q, oi_q, oj_q, ok_q;
  logic [1:0]    dim_q, ax_q;
  logic [2:0]    step_q;
  logic [NODE_IDX_W-1:0] idx_q;

  logic signed [31:0] pt_q [3];
  logic signed [31:0] xq_q;
  logic signed [63:0] acc_q, sum_q, t_q, v_q, dx_q, dy_q, dz_q;
  logic [MAX_NODES-1:0] hit_q;
  logic onnode_q;
  logic signed [WEIGHT_W-1:0] bary_q [MAX_NODES];
  logic signed [63:0] val_q [3][MAX_NODES];
  logic signed [63:0] der_q [3][MAX_NODES];

  logic [NODE_IDX_W-1:0] node_index_q;
  logic signed [31:0] shape_q, odx_q, ody_q, odz_q;
  logic last_q;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;
  logic signed [63:0] alu_a, alu_b, alu_res;

  logic in_fire, out_free, cfg_hit, j_last, ax_last, o_last, step_done;
  logic [CW-1:0] n_eff;
  logic [1:0] dim_eff;
  logic signed [32:0] diff;
  logic signed [63:0] diff64, bary_j;
  logic signed [31:0] pt_cur;
  logic [MAX_NODES-1:0] hit_d;
  logic signed [63:0] v0, v1, v2, d0, d1, d2;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > MAX65) begin
      return MAX65[63:0];
    end else if (s < -MAX65) begin
      return -MAX65[63:0];
    end
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  tlse_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .rsp_o  (alu_rsp),
    .res_o  (alu_res)
  );

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign cfg_hit  = cfg_we_i && (cfg_idx_i <= REG_COORD3);
  assign j_last   = (j_q + CW'(1)) == n_q;
  assign ax_last  = (ax_q + 2'd1) == dim_q;
  assign o_last   = ((oi_q + CW'(1)) == n_q)
                 && (dim_q == DIM_LINE || (oj_q + CW'(1)) == n_q)
                 && (dim_q != DIM_BRICK || (ok_q + CW'(1)) == n_q);

  assign diff   = 33'(xq_q) - 33'(node_coord_q[CSW'(i_q)]);
  assign diff64 = 64'(diff);
  assign bary_j = 64'(bary_q[IW'(j_q)]);
  assign pt_cur = pt_q[ax_q];
  assign v0 = val_q[0][IW'(oi_q)];
  assign v1 = val_q[1][IW'(oj_q)];
  assign v2 = val_q[2][IW'(ok_q)];
  assign d0 = der_q[0][IW'(oi_q)];
  assign d1 = der_q[1][IW'(oj_q)];
  assign d2 = der_q[2][IW'(ok_q)];

  always_comb begin
    if (node_count_q < 3'd2) begin
      n_eff = CW'(2);
    end else if (node_count_q > 3'(MAX_NODES)) begin
      n_eff = CW'(MAX_NODES);
    end else begin
      n_eff = CW'(node_count_q);
    end
    dim_eff = (dimension_q == 2'd0) ? DIM_LINE : dimension_q;
    for (int m = 0; m < MAX_NODES; m++) begin
      hit_d[m] = (pt_cur == node_coord_q[m]) && (CW'(m) < n_q);
    end
    case (dim_q)
      DIM_QUAD:  step_done = step_q == LAST_STEP_QUAD;
      DIM_BRICK: step_done = step_q == LAST_STEP_BRICK;
      default:   step_done = step_q == LAST_STEP_LINE;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_fire) state_d = wvalid_q ? S_B_START : S_W_J;
      S_W_J:     state_d = S_W_I;
      S_W_I: begin
        if (i_q == n_q) state_d = S_W_R;
        else if (i_q != j_q) state_d = S_W_M;
      end
      S_W_M:     if (alu_rsp.done) state_d = S_W_I;
      S_W_R:     if (alu_rsp.done) state_d = j_last ? S_B_START : S_W_J;
      S_B_START: state_d = S_B_P;
      S_B_P: begin
        if (i_q == n_q) state_d = S_B_V;
        else if (i_q != j_q) state_d = S_B_PM;
      end
      S_B_PM:    if (alu_rsp.done) state_d = S_B_P;
      S_B_V:     state_d = onnode_q ? S_B_K : S_B_VM;
      S_B_VM:    if (alu_rsp.done) state_d = S_B_K;
      S_B_K: begin
        if (k_q == n_q) state_d = S_B_DM;
        else if (k_q != j_q) state_d = S_B_T;
      end
      S_B_T: begin
        if (i_q == n_q) state_d = S_B_K;
        else if (i_q != j_q && i_q != k_q) state_d = S_B_TM;
      end
      S_B_TM:    if (alu_rsp.done) state_d = S_B_T;
      S_B_DM: begin
        if (alu_rsp.done) begin
          if (!j_last) state_d = S_B_P;
          else state_d = ax_last ? S_O_ISSUE : S_B_START;
        end
      end
      S_O_ISSUE: state_d = S_O_WAIT;
      S_O_WAIT:  if (alu_rsp.done) state_d = step_done ? S_O_EMIT : S_O_ISSUE;
      S_O_EMIT:  if (out_free) state_d = o_last ? S_IDLE : S_O_ISSUE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    alu_req.start = 1'b0;
    alu_req.op    = OP_MUL;
    alu_req.sh    = SH_FRAC;
    alu_a         = acc_q;
    alu_b         = diff64;
    unique case (state_q)
      S_IDLE: in_ready_o = 1'b1;
      S_W_I: begin
        if (i_q == n_q) begin
          alu_req.start = 1'b1;
          alu_req.op    = OP_RECIP;
        end else if (i_q != j_q) begin
          alu_req.start = 1'b1;
        end
      end
      S_B_P: alu_req.start = (i_q != n_q) && (i_q != j_q);
      S_B_V: begin
        alu_req.start = !onnode_q;
        alu_req.sh    = SH_WEIGHT;
        alu_a         = bary_j;
        alu_b         = acc_q;
      end
      S_B_K: begin
        alu_req.start = (k_q == n_q);
        alu_req.sh    = SH_WEIGHT;
        alu_a         = bary_j;
        alu_b         = sum_q;
      end
      S_B_T: alu_req.start = (i_q != n_q) && (i_q != j_q) && (i_q != k_q);
      S_O_ISSUE: begin
        alu_req.start = 1'b1;
        case (dim_q)
          DIM_QUAD: begin
            case (step_q)
              3'd0:    begin alu_a = v0; alu_b = v1; end
              3'd1:    begin alu_a = d0; alu_b = v1; alu_req.sh = SH_PDERIV; end
              default: begin alu_a = v0; alu_b = d1; alu_req.sh = SH_PDERIV; end
            endcase
          end
          DIM_BRICK: begin
            case (step_q)
              3'd0:    begin alu_a = v0;    alu_b = v1; end
              3'd1:    begin alu_a = t_q;   alu_b = v2; end
              3'd2:    begin alu_a = d0;    alu_b = v1; end
              3'd3:    begin alu_a = acc_q; alu_b = v2; alu_req.sh = SH_PDERIV; end
              3'd4:    begin alu_a = v0;    alu_b = d1; end
              3'd5:    begin alu_a = acc_q; alu_b = v2; alu_req.sh = SH_PDERIV; end
              default: begin alu_a = t_q;   alu_b = d2; alu_req.sh = SH_PDERIV; end
            endcase
          end
          default: begin
            alu_a      = d0;
            alu_b      = 64'sd1;
            alu_req.sh = SH_DERIV;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= NODE_COUNT_RST;
      dimension_q  <= DIM_RST;
      for (int m = 0; m < NUM_COORDS; m++) begin
        node_coord_q[m] <= COORD_RST[m];
      end
      wvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
      n_q  <= '0;
      i_q  <= '0;
      j_q  <= '0;
      k_q  <= '0;
      oi_q <= '0;
      oj_q <= '0;
      ok_q <= '0;
      dim_q  <= DIM_LINE;
      ax_q   <= '0;
      step_q <= '0;
      idx_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_O_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: if (in_fire) begin
          n_q   <= n_eff;
          dim_q <= dim_eff;
          i_q   <= '0;
          j_q   <= '0;
          ax_q  <= '0;
        end
        S_W_J: i_q <= '0;
        S_W_I: if (i_q != n_q && i_q == j_q) i_q <= i_q + CW'(1);
        S_W_M: if (alu_rsp.done) i_q <= i_q + CW'(1);
        S_W_R: if (alu_rsp.done) begin
          j_q <= j_q + CW'(1);
          i_q <= j_q + CW'(1);
          if (j_last) begin
            wvalid_q <= 1'b1;
          end
        end
        S_B_START: begin
          i_q <= '0;
          j_q <= '0;
        end
        S_B_P:  if (i_q != n_q && i_q == j_q) i_q <= i_q + CW'(1);
        S_B_PM: if (alu_rsp.done) i_q <= i_q + CW'(1);
        S_B_V:  k_q <= '0;
        S_B_K: begin
          if (k_q != n_q) begin
            if (k_q == j_q) k_q <= k_q + CW'(1);
            else i_q <= '0;
          end
        end
        S_B_T: begin
          if (i_q == n_q) k_q <= k_q + CW'(1);
          else if (i_q == j_q || i_q == k_q) i_q <= i_q + CW'(1);
        end
        S_B_TM: if (alu_rsp.done) i_q <= i_q + CW'(1);
        S_B_DM: if (alu_rsp.done) begin
          i_q <= '0;
          if (j_last) begin
            j_q    <= '0;
            ax_q   <= ax_q + 2'd1;
            oi_q   <= '0;
            oj_q   <= '0;
            ok_q   <= '0;
            idx_q  <= '0;
            step_q <= '0;
          end else begin
            j_q <= j_q + CW'(1);
          end
        end
        S_O_WAIT: if (alu_rsp.done && !step_done) step_q <= step_q + 3'd1;
        S_O_EMIT: if (out_free) begin
          step_q <= '0;
          idx_q  <= idx_q + NODE_IDX_W'(1);
          if ((oi_q + CW'(1)) == n_q) begin
            oi_q <= '0;
            if ((oj_q + CW'(1)) == n_q) begin
              oj_q <= '0;
              ok_q <= ok_q + CW'(1);
            end else begin
              oj_q <= oj_q + CW'(1);
            end
          end else begin
            oi_q <= oi_q + CW'(1);
          end
        end
        default: ;
      endcase
      if (cfg_we_i) begin
        unique case (cfg_idx_i) inside
          REG_NODE_COUNT: node_count_q <= cfg_wdata_i[2:0];
          REG_DIMENSION:  dimension_q  <= cfg_wdata_i[1:0];
          REG_COORD0, REG_COORD1, REG_COORD2, REG_COORD3:
            node_coord_q[CSW'(cfg_idx_i - REG_COORD0)] <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cfg_hit) begin
        wvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (in_fire) begin
        pt_q[0] <= coord_x_i;
        pt_q[1] <= coord_y_i;
        pt_q[2] <= coord_z_i;
      end
      S_W_J: begin
        xq_q  <= node_coord_q[CSW'(i_q)];
        acc_q <= ONE;
      end
      S_W_M, S_B_PM, S_B_TM: if (alu_rsp.done) acc_q <= alu_res;
      S_W_R: if (alu_rsp.done) begin
        bary_q[IW'(j_q)] <= alu_res[WEIGHT_W-1:0];
      end
      S_B_START: begin
        xq_q     <= pt_cur;
        hit_q    <= hit_d;
        onnode_q <= |hit_d;
        acc_q    <= ONE;
      end
      S_B_V: begin
        sum_q <= '0;
        if (onnode_q) begin
          val_q[ax_q][IW'(j_q)] <= hit_q[IW'(j_q)] ? ONE : 64'sd0;
        end
      end
      S_B_VM: if (alu_rsp.done) val_q[ax_q][IW'(j_q)] <= alu_res;
      S_B_K: if (k_q != n_q && k_q != j_q) acc_q <= ONE;
      S_B_T: if (i_q == n_q) sum_q <= sat_add(sum_q, acc_q);
      S_B_DM: if (alu_rsp.done) begin
        der_q[ax_q][IW'(j_q)] <= alu_res;
        acc_q <= ONE;
      end
      S_O_WAIT: if (alu_rsp.done) begin
        case (dim_q)
          DIM_QUAD: begin
            case (step_q)
              3'd0:    v_q  <= alu_res;
              3'd1:    dx_q <= alu_res;
              default: dy_q <= alu_res;
            endcase
          end
          DIM_BRICK: begin
            case (step_q)
              3'd0:       t_q   <= alu_res;
              3'd1:       v_q   <= alu_res;
              3'd2, 3'd4: acc_q <= alu_res;
              3'd3:       dx_q  <= alu_res;
              3'd5:       dy_q  <= alu_res;
              default:    dz_q  <= alu_res;
            endcase
          end
          default: dx_q <= alu_res;
        endcase
      end
      S_O_EMIT: if (out_free) begin
        node_index_q <= idx_q;
        shape_q      <= (dim_q == DIM_LINE) ? sat32(v0) : sat32(v_q);
        odx_q        <= sat32(dx_q);
        ody_q        <= (dim_q == DIM_LINE) ? 32'sd0 : sat32(dy_q);
        odz_q        <= (dim_q == DIM_BRICK) ? sat32(dz_q) : 32'sd0;
        last_q       <= o_last;
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign node_index_o  = node_index_q;
  assign shape_value_o = shape_q;
  assign deriv_x_o     = odx_q;
  assign deriv_y_o     = ody_q;
  assign deriv_z_o     = odz_q;
  assign last_node_o   = last_q;

  `TLSE_ASSERT_NEXT(a_cfg_clears_weights, cfg_hit, !wvalid_q, "Weights stayed valid after a write")
  `TLSE_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready_o, "Ready held after an input beat")
  `TLSE_ASSERT(a_done_in_wait, alu_rsp.done |-> (state_q == S_W_M || state_q == S_W_R || state_q == S_B_PM || state_q == S_B_VM || state_q == S_B_TM || state_q == S_B_DM || state_q == S_O_WAIT), "ALU result with no waiting step")

endmodule

// ===== design/tlse_alu.sv =====
`include "tensor_lagrange_shape_eval_defines.svh"

module tlse_alu #(
  parameter int FRAC_BITS = 30
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlse_pkg::alu_req_t  req_i,
  input  logic signed [63:0]  a_i,
  input  logic signed [63:0]  b_i,
  output tlse_pkg::alu_rsp_t  rsp_o,
  output logic signed [63:0]  res_o
);
  import tlse_pkg::*;

  localparam int DIV_TOP = 2 * FRAC_BITS + 6;
  localparam int BW      = $clog2(DIV_TOP + 1);
  localparam int SH_F    = FRAC_BITS;
  localparam int SH_W    = FRAC_BITS + 6;
  localparam int SH_PD   = FRAC_BITS + 4;
  localparam int SH_FD   = 4;

  alu_st_e st_q, st_d;
  logic [1:0]          cnt_q;
  logic [BW-1:0]       bit_q;
  logic [63:0]         ua_q, ub_q;
  logic                neg_q, zero_q, sat_q;
  sh_sel_e             sh_q;
  logic [127:0]        prod_q;
  logic [64:0]         rem_q;
  logic [WEIGHT_W-1:0] quo_q;

  logic [63:0]  a_mag, b_mag;
  logic [31:0]  a_part, b_part;
  logic [63:0]  pp;
  logic [127:0] pp_sh, shifted;
  logic [63:0]  mag;
  logic [64:0]  r2, r2x;
  logic         ge, rbit;
  logic [WEIGHT_W:0]   qs;
  logic [WEIGHT_W-1:0] qm;
  logic signed [63:0]  mul_res, div_res;

  function automatic logic [127:0] rnd_const(input sh_sel_e s);
    logic [127:0] r;
    case (s)
      SH_FRAC:   r = 128'd1 << (SH_F - 1);
      SH_WEIGHT: r = 128'd1 << (SH_W - 1);
      SH_PDERIV: r = 128'd1 << (SH_PD - 1);
      default:   r = 128'd1 << (SH_FD - 1);
    endcase
    return r;
  endfunction

  assign a_mag  = a_i[63] ? (~a_i + 64'd1) : a_i;
  assign b_mag  = b_i[63] ? (~b_i + 64'd1) : b_i;
  assign a_part = cnt_q[1] ? ua_q[63:32] : ua_q[31:0];
  assign b_part = cnt_q[0] ? ub_q[63:32] : ub_q[31:0];
  assign pp     = a_part * b_part;

  always_comb begin
    case (cnt_q)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    case (sh_q)
      SH_FRAC:   shifted = prod_q >> SH_F;
      SH_WEIGHT: shifted = prod_q >> SH_W;
      SH_PDERIV: shifted = prod_q >> SH_PD;
      default:   shifted = prod_q >> SH_FD;
    endcase
    mag     = (|shifted[127:63]) ? DATA_MAX : shifted[63:0];
    mul_res = neg_q ? -$signed(mag) : $signed(mag);

    r2  = {rem_q[63:0], bit_q == BW'(DIV_TOP)};
    ge  = r2 >= {1'b0, ua_q};
    r2x = {rem_q[63:0], 1'b0};
    rbit = !sat_q && (r2x >= {1'b0, ua_q});
    qs  = {1'b0, quo_q} + {{WEIGHT_W{1'b0}}, rbit};
    qm  = (sat_q || qs > {1'b0, WEIGHT_LIMIT}) ? WEIGHT_LIMIT : qs[WEIGHT_W-1:0];
    if (zero_q) begin
      div_res = '0;
    end else if (neg_q) begin
      div_res = -$signed({{(64-WEIGHT_W){1'b0}}, qm});
    end else begin
      div_res = $signed({{(64-WEIGHT_W){1'b0}}, qm});
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      A_IDLE: if (req_i.start) begin
        st_d = (req_i.op == OP_MUL) ? A_MUL : A_DIV;
      end
      A_MUL:  if (cnt_q == 2'd3) begin
        st_d = A_FIN;
      end
      A_FIN:  st_d = A_IDLE;
      A_DIV:  if (bit_q == '0) begin
        st_d = A_DFIN;
      end
      A_DFIN: st_d = A_IDLE;
      default: st_d = A_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.done = (st_q == A_FIN) || (st_q == A_DFIN);
    res_o      = (st_q == A_DFIN) ? div_res : mul_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= A_IDLE;
      cnt_q <= '0;
      bit_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == A_IDLE && req_i.start) begin
        cnt_q <= '0;
        bit_q <= BW'(DIV_TOP);
      end else if (st_q == A_MUL) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (st_q == A_DIV && bit_q != '0) begin
        bit_q <= bit_q - BW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == A_IDLE && req_i.start) begin
      ua_q   <= a_mag;
      ub_q   <= b_mag;
      neg_q  <= a_i[63] ^ ((req_i.op == OP_MUL) & b_i[63]);
      zero_q <= (a_i == '0);
      sh_q   <= req_i.sh;
      prod_q <= rnd_const(req_i.sh);
      rem_q  <= '0;
      quo_q  <= '0;
      sat_q  <= 1'b0;
    end else if (st_q == A_MUL) begin
      prod_q <= prod_q + pp_sh;
    end else if (st_q == A_DIV) begin
      rem_q <= ge ? (r2 - {1'b0, ua_q}) : r2;
      if (bit_q >= BW'(WEIGHT_W - 1)) begin
        if (ge) begin
          sat_q <= 1'b1;
        end
      end else begin
        quo_q <= {quo_q[WEIGHT_W-2:0], ge};
      end
    end
  end

  `TLSE_ASSERT(a_start_when_idle, req_i.start |-> st_q == A_IDLE, "ALU started while busy")
  `TLSE_ASSERT_NEXT(a_done_single, rsp_o.done, !rsp_o.done, "ALU done held two cycles")

endmodule
